@@ design/http_header_field_parser_core_assert.svh @@
// Assertion macros for the HTTP header field parser core.
// Included by the modules that check their own logic; no other dependencies.
`ifndef HTTP_HEADER_FIELD_PARSER_CORE_ASSERT_SVH
`define HTTP_HEADER_FIELD_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset
`define HHFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhfp assertion failed");

// Next-cycle implication, off during reset
`define HHFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhfp assertion failed");

`endif

@@ design/hhfp_pkg.sv @@
// Shared types, codes and character classes for the HTTP header field parser.
// No dependencies; the front, queue, back and core modules import it.
`default_nettype none

package hhfp_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_EOI     = 2'd1,
    OP_RESTART = 2'd2,
    OP_RSVD    = 2'd3
  } op_t;

  // Result kinds
  localparam logic [2:0] K_NAME  = 3'd0;
  localparam logic [2:0] K_VALUE = 3'd1;
  localparam logic [2:0] K_FEND  = 3'd2;
  localparam logic [2:0] K_HEND  = 3'd3;
  localparam logic [2:0] K_ERR   = 3'd4;

  // Error codes
  localparam logic [3:0] E_COLON     = 4'd0;
  localparam logic [3:0] E_EMPTY     = 4'd1;
  localparam logic [3:0] E_FIELDS    = 4'd2;
  localparam logic [3:0] E_CONTENT   = 4'd3;
  localparam logic [3:0] E_LF        = 4'd4;
  localparam logic [3:0] E_CR        = 4'd5;
  localparam logic [3:0] E_HDR_BIG   = 4'd6;
  localparam logic [3:0] E_FIELD_BIG = 4'd7;
  localparam logic [3:0] E_EARLY_END = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] CFG_STRICT    = 2'd0;
  localparam logic [1:0] CFG_MAX_HDR   = 2'd1;
  localparam logic [1:0] CFG_MAX_FIELD = 2'd2;
  localparam logic [1:0] CFG_MAX_COUNT = 2'd3;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Parser line state
  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_NAME    = 8'b0000_0010,
    ST_OWS     = 8'b0000_0100,
    ST_CONTENT = 8'b0000_1000,
    ST_LF      = 8'b0001_0000,
    ST_NEWLINE = 8'b0010_0000,
    ST_EOH_LF  = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } pstate_t;

  // One result
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] value_length;
    logic [3:0]  error_code;
    logic        last;
  } res_t;

  // Results of one request: up to two
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } pair_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] b,
                                  logic [15:0] len, logic [3:0] code);
    res_t r;
    r.kind         = kind;
    r.out_byte     = b;
    r.value_length = len;
    r.error_code   = code;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic is_token(logic [7:0] c);
    logic t;
    t = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
        ((c >= 8'h61) && (c <= 8'h7A));
    unique case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
      8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: t = 1'b1;
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic is_text(logic [7:0] c);
    return (c == CH_HT) || ((c >= 8'h20) && (c <= 8'h7E)) || c[7];
  endfunction

endpackage

`default_nettype wire

@@ design/hhfp_ifs.sv @@
// Valid/ready channel interfaces: input requests, results, configuration writes.
// No dependencies.
`default_nettype none

interface hhfp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] in_byte;
  modport source (output valid, op, in_byte, input ready);
  modport sink   (input valid, op, in_byte, output ready);
endinterface

interface hhfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] value_length;
  logic [3:0]  error_code;
  logic        last;
  modport source (output valid, kind, out_byte, value_length, error_code, last,
                  input ready);
  modport sink   (input valid, kind, out_byte, value_length, error_code, last,
                  output ready);
endinterface

interface hhfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/http_header_field_parser_core.sv @@
// HTTP header field parser core: one header byte per request, results out.
// Results go into a queue entry and then into the output register that
// offers them. Throughput: 1 request per cycle unless the queue is full; a
// request with two results (field end plus the next byte's result) holds
// the single output register until both results of the request are taken.
// A 4-entry result queue separates the grammar FSM from the output register.
// Reset: synchronous active-low rst_n clears parse state, queue and config.
`default_nettype none

module http_header_field_parser_core #(
  parameter int VALUE_LEN_BITS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  hhfp_in_if.sink      in_ch,
  hhfp_out_if.source   out_ch,
  hhfp_cfg_if.sink     cfg_ch
);
  import hhfp_pkg::*;

  logic  q_full;
  logic  push;
  pair_t push_pair;
  logic  pop;
  logic  head_valid;
  pair_t head_pair;

  // Grammar FSM and config registers
  hhfp_front #(
    .VALUE_LEN_BITS(VALUE_LEN_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push      (push),
    .push_pair (push_pair)
  );

  // Result queue
  hhfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_pair  (push_pair),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_pair  (head_pair)
  );

  // Output serializer
  hhfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_pair  (head_pair),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

@@ design/hhfp_front.sv @@
// Front end: accepts requests and config writes, runs the field grammar FSM
// and packs the results of each request into one queue entry. Uses hhfp_pkg.
`default_nettype none

module hhfp_front #(
  parameter int VALUE_LEN_BITS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  hhfp_in_if.sink            in_ch,
  hhfp_cfg_if.sink           cfg_ch,
  input  wire                q_full,
  output logic               push,
  output hhfp_pkg::pair_t    push_pair
);
  import hhfp_pkg::*;

  localparam int VLB = VALUE_LEN_BITS;

  // Configuration registers
  logic        strict_r;
  logic [31:0] max_hdr_r;
  logic [31:0] max_field_r;
  logic [15:0] max_count_r;

  // Parse state
  pstate_t        st_r, st_nxt;
  logic [31:0]    tb_r, tb_nxt;
  logic [31:0]    fb_r, fb_nxt;
  logic [15:0]    fs_r, fs_nxt;
  logic           ne_r, ne_nxt;
  logic [VLB-1:0] vc_r, vc_nxt;
  logic [VLB-1:0] tc_r, tc_nxt;
  logic           el_r, el_nxt;
  logic [3:0]     ec_r, ec_nxt;

  logic           in_acc;
  logic [7:0]     c;
  logic           c_ws;
  logic [VLB-1:0] vc_inc;
  logic [31:0]    trim32;
  logic [15:0]    trim_len;
  logic [16:0]    cnt_inc;
  logic [31:0]    fb_base;
  logic           feed_v, fend_v, main_v, fail_v, fb_clear;
  logic           line_start, in_name, in_content;
  logic [3:0]     fail_code;
  res_t           main_r;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && !q_full;
  assign c            = in_ch.in_byte;
  assign c_ws         = (c == CH_SP) || (c == CH_HT);
  assign vc_inc       = (vc_r != '1) ? vc_r + 1'b1 : vc_r;
  assign trim32       = 32'(tc_r);
  assign trim_len     = (|trim32[31:16]) ? 16'hFFFF : trim32[15:0];
  assign cnt_inc      = {1'b0, fs_r} + 17'd1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r    <= 1'b0;
      max_hdr_r   <= '0;
      max_field_r <= '0;
      max_count_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_STRICT:    strict_r    <= cfg_ch.data[0];
        CFG_MAX_HDR:   max_hdr_r   <= cfg_ch.data;
        CFG_MAX_FIELD: max_field_r <= cfg_ch.data;
        CFG_MAX_COUNT: max_count_r <= cfg_ch.data[15:0];
      endcase
    end
  end

  // Decode one request
  always_comb begin
    st_nxt = st_r;  tb_nxt = tb_r;  fb_nxt = fb_r;  fs_nxt = fs_r;
    ne_nxt = ne_r;  vc_nxt = vc_r;  tc_nxt = tc_r;  el_nxt = el_r;
    ec_nxt = ec_r;
    feed_v = 1'b0;  fend_v = 1'b0;  main_v = 1'b0;  main_r = '0;
    fail_v = 1'b0;  fail_code = E_COLON;  fb_clear = 1'b0;
    line_start = 1'b0;  in_name = 1'b0;  in_content = 1'b0;
    fb_base = fb_r;

    if (in_acc) begin
      priority if (op_t'(in_ch.op) == OP_RESTART) begin
        st_nxt = ST_INIT;  tb_nxt = '0;  fb_nxt = '0;  fs_nxt = '0;
        ne_nxt = 1'b0;  vc_nxt = '0;  tc_nxt = '0;  el_nxt = 1'b0;
        ec_nxt = E_COLON;
      end else if (op_t'(in_ch.op) == OP_RSVD) begin
        // drop
      end else if (el_r) begin
        main_v = 1'b1;
        main_r = mk_res(K_ERR, 8'd0, 16'd0, ec_r);
      end else if (st_r == ST_DONE) begin
        // drop until restart
      end else if (op_t'(in_ch.op) == OP_EOI) begin
        fail_v = 1'b1;  fail_code = E_EARLY_END;
      end else if ((max_hdr_r != '0) && (tb_r >= max_hdr_r)) begin
        fail_v = 1'b1;  fail_code = E_HDR_BIG;
      end else if ((max_field_r != '0) && (fb_r > max_field_r)) begin
        fail_v = 1'b1;  fail_code = E_FIELD_BIG;
      end else begin
        feed_v = 1'b1;
      end
    end

    if (feed_v) begin
      // Line state dispatch
      unique case (st_r)
        ST_NEWLINE: begin
          if (c_ws) begin
            // folded space counts toward the length but not the trimmed length
            vc_nxt = vc_inc;
            st_nxt = ST_OWS;
            main_v = 1'b1;
            main_r = mk_res(K_VALUE, CH_SP, 16'd0, 4'd0);
          end else begin
            fend_v     = 1'b1;
            fb_clear   = 1'b1;
            line_start = 1'b1;
          end
        end
        ST_INIT:    line_start = 1'b1;
        ST_NAME:    in_name    = 1'b1;
        ST_OWS:     in_content = !c_ws;
        ST_CONTENT: in_content = 1'b1;
        ST_LF: begin
          if (c != CH_LF) begin
            fail_v = 1'b1;  fail_code = E_LF;
          end else begin
            st_nxt = ST_NEWLINE;
          end
        end
        ST_EOH_LF: begin
          if (c != CH_LF) begin
            fail_v = 1'b1;  fail_code = E_CR;
          end else begin
            st_nxt   = ST_DONE;
            fb_clear = 1'b1;
            main_v   = 1'b1;
            main_r   = mk_res(K_HEND, 8'd0, 16'd0, 4'd0);
          end
        end
        default: ;
      endcase

      // Start of a line: empty line or first name byte
      if (line_start) begin
        vc_nxt = '0;
        tc_nxt = '0;
        ne_nxt = 1'b0;
        priority if (c == CH_CR) begin
          st_nxt = ST_EOH_LF;
        end else if (c == CH_LF) begin
          st_nxt = ST_DONE;
          main_v = 1'b1;
          main_r = mk_res(K_HEND, 8'd0, 16'd0, 4'd0);
        end else begin
          st_nxt  = ST_NAME;
          in_name = 1'b1;
        end
      end

      // Field name and colon
      if (in_name) begin
        priority if (is_token(c)) begin
          ne_nxt = 1'b1;
          main_v = 1'b1;
          main_r = mk_res(K_NAME, c, 16'd0, 4'd0);
        end else if (!ne_nxt) begin
          fail_v = 1'b1;  fail_code = E_EMPTY;
        end else if (c != CH_COLON) begin
          fail_v = 1'b1;  fail_code = E_COLON;
        end else if ((max_count_r != '0) && (cnt_inc > {1'b0, max_count_r})) begin
          fail_v = 1'b1;  fail_code = E_FIELDS;
        end else begin
          fs_nxt = cnt_inc[16] ? 16'hFFFF : cnt_inc[15:0];
          st_nxt = ST_OWS;
        end
      end

      // Field content
      if (in_content) begin
        st_nxt = ST_CONTENT;
        priority if (is_text(c)) begin
          vc_nxt = vc_inc;
          if (!c_ws) tc_nxt = vc_inc;
          main_v = 1'b1;
          main_r = mk_res(K_VALUE, c, 16'd0, 4'd0);
        end else if (c == CH_CR) begin
          st_nxt = ST_LF;
        end else if (c == CH_LF) begin
          st_nxt = ST_NEWLINE;
        end else if (strict_r) begin
          fail_v = 1'b1;  fail_code = E_CONTENT;
        end else begin
          // drop the byte
        end
      end

      // Advance byte counters
      tb_nxt  = (tb_r != '1) ? tb_r + 32'd1 : tb_r;
      fb_base = fb_clear ? 32'd0 : fb_r;
      fb_nxt  = ((st_nxt != ST_DONE) && (fb_base != '1)) ? fb_base + 32'd1 : fb_base;
    end

    // Latch an error
    if (fail_v) begin
      el_nxt = 1'b1;
      ec_nxt = fail_code;
      main_v = 1'b1;
      main_r = mk_res(K_ERR, 8'd0, 16'd0, fail_code);
    end
  end

  // Pack results for the queue
  always_comb begin
    push_pair = '0;
    if (fend_v) begin
      push_pair.r0 = mk_res(K_FEND, 8'd0, trim_len, 4'd0);
      push_pair.r1 = main_r;
      push_pair.cnt = main_v ? 2'd2 : 2'd1;
    end else begin
      push_pair.r0  = main_r;
      push_pair.cnt = main_v ? 2'd1 : 2'd0;
    end
    if (push_pair.cnt == 2'd2) push_pair.r1.last = 1'b1;
    else                       push_pair.r0.last = 1'b1;
  end

  assign push = in_acc && (push_pair.cnt != 2'd0);

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_INIT;
      tb_r <= '0;
      fb_r <= '0;
      fs_r <= '0;
      ne_r <= 1'b0;
      vc_r <= '0;
      tc_r <= '0;
      el_r <= 1'b0;
      ec_r <= E_COLON;
    end else begin
      st_r <= st_nxt;
      tb_r <= tb_nxt;
      fb_r <= fb_nxt;
      fs_r <= fs_nxt;
      ne_r <= ne_nxt;
      vc_r <= vc_nxt;
      tc_r <= tc_nxt;
      el_r <= el_nxt;
      ec_r <= ec_nxt;
    end
  end

`include "http_header_field_parser_core_assert.svh"

  `HHFP_ASSERT_NEXT(a_err_sticky, clk, rst_n, in_acc && el_r && (in_ch.op != OP_RESTART), el_r)
  `HHFP_ASSERT_IMPL(a_two_last, clk, rst_n, push && (push_pair.cnt == 2'd2), push_pair.r1.last && !push_pair.r0.last)
  `HHFP_ASSERT_IMPL(a_done_quiet, clk, rst_n, in_acc && (st_r == ST_DONE) && !el_r, !push)

endmodule

`default_nettype wire

@@ design/hhfp_queue.sv @@
// Result queue between front and back: QDEPTH entries, each holding the
// results of one request. Uses hhfp_pkg.
`default_nettype none

module hhfp_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  hhfp_pkg::pair_t  push_pair,
  output logic             full,
  input  wire              pop,
  output logic             head_valid,
  output hhfp_pkg::pair_t  head_pair
);
  import hhfp_pkg::*;

  pair_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_pair  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_pair;
  end

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/hhfp_back.sv @@
// Back end: takes queue entries and sends their results one per cycle, while
// the receiver is ready, from an output register. Uses hhfp_pkg.
`default_nettype none

module hhfp_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              head_valid,
  input  hhfp_pkg::pair_t  head_pair,
  output logic             pop,
  hhfp_out_if.source       out_ch
);
  import hhfp_pkg::*;

  logic  hold_v_r;
  pair_t pair_r;
  logic  sel_r;
  logic  out_acc;
  logic  finish;
  res_t  cur;

  assign cur     = sel_r ? pair_r.r1 : pair_r.r0;
  assign out_acc = hold_v_r && out_ch.ready;
  assign finish  = out_acc && (sel_r || (pair_r.cnt != 2'd2));
  assign pop     = head_valid && (!hold_v_r || finish);

  assign out_ch.valid        = hold_v_r;
  assign out_ch.kind         = cur.kind;
  assign out_ch.out_byte     = cur.out_byte;
  assign out_ch.value_length = cur.value_length;
  assign out_ch.error_code   = cur.error_code;
  assign out_ch.last         = cur.last;

  // Load the next entry, or step to its second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      sel_r    <= 1'b0;
    end else begin
      if (pop) begin
        hold_v_r <= 1'b1;
        sel_r    <= 1'b0;
      end else if (finish) begin
        hold_v_r <= 1'b0;
        sel_r    <= 1'b0;
      end else if (out_acc) begin
        sel_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) pair_r <= head_pair;
  end

`include "http_header_field_parser_core_assert.svh"

  `HHFP_ASSERT_IMPL(a_sel_pair, clk, rst_n, hold_v_r && sel_r, pair_r.cnt == 2'd2)
  `HHFP_ASSERT_NEXT(a_last_rewinds, clk, rst_n, out_acc && cur.last, !sel_r)
  `HHFP_ASSERT_IMPL(a_pop_room, clk, rst_n, pop, !hold_v_r || finish)

endmodule

`default_nettype wire

@@ bench/http_header_field_parser_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for http_header_field_parser_core: sends header bytes, end and
// restart requests, predicts each result in order and compares every field.
// Depends on hhfp_pkg and the channel interfaces from the design sources.

module http_header_field_parser_core_tb;
  import hhfp_pkg::*;

  localparam int          CLK_HALF      = 4;
  localparam int          RESET_CYCLES  = 9;
  localparam int          CYCLE_LIMIT   = 2_000_000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          GAP_PCT       = 24;
  localparam int          PHASE_ITEMS   = 170;
  localparam int          REPORT_MAX    = 10;
  localparam logic [15:0] LEN_MAX       = 16'hFFFF;
  localparam logic [31:0] WORD_MAX      = 32'hFFFF_FFFF;

  typedef struct packed {
    op_t        op;
    logic [7:0] b;
  } req_t;

  typedef struct {
    op_t        op;
    logic [7:0] b;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  hhfp_in_if  in_ch();
  hhfp_out_if out_ch();
  hhfp_cfg_if cfg_ch();

  http_header_field_parser_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor copy of the configuration
  logic        strict_on;
  logic [31:0] hdr_limit;
  logic [31:0] line_limit;
  logic [15:0] count_limit;

  // Predictor copy of the parse state
  pstate_t     ps;
  logic [31:0] hdr_bytes;
  logic [31:0] line_bytes;
  logic [15:0] fields_done;
  logic        name_seen;
  logic [15:0] val_len;
  logic [15:0] trim_len;
  logic        err_on;
  logic [3:0]  err_cd;

  res_t     step_res[$];
  res_t     pending_results[$];
  req_t     hdr_seq[$];
  dir_row_t dir_rows[$];

  int  items_sent;
  int  mismatches;
  int  cycles;
  int  hold_left;
  logic gaps_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic take_gap();
    return gaps_on && ($urandom_range(99) < GAP_PCT);
  endfunction

  function automatic logic is_tchar(logic [7:0] c);
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
      default: return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                      (c >= "a" && c <= "z");
    endcase
  endfunction

  function automatic logic is_vchar(logic [7:0] c);
    return (c == CH_HT) || (c >= 8'h20 && c <= 8'h7E) || (c >= 8'h80);
  endfunction

  function automatic void emit(logic [2:0] k, logic [7:0] b, logic [15:0] len,
                               logic [3:0] code);
    res_t r;
    r.kind         = k;
    r.out_byte     = b;
    r.value_length = len;
    r.error_code   = code;
    r.last         = 1'b0;
    step_res.push_back(r);
  endfunction

  // Latch the error and report it
  function automatic void fail_with(logic [3:0] code);
    err_on = 1'b1;
    err_cd = code;
    emit(K_ERR, 8'h00, 16'h0000, code);
  endfunction

  // Grow the value; trailing blanks do not count toward the trimmed length
  function automatic void add_char(logic [7:0] c);
    if (val_len != LEN_MAX) val_len++;
    if (c != CH_SP && c != CH_HT) trim_len = val_len;
  endfunction

  function automatic void clear_parse();
    ps          = ST_INIT;
    hdr_bytes   = '0;
    line_bytes  = '0;
    fields_done = '0;
    name_seen   = 1'b0;
    val_len     = '0;
    trim_len    = '0;
    err_on      = 1'b0;
    err_cd      = E_COLON;
  endfunction

  // Line grammar for one accepted byte; later stages take over where a byte
  // passes on to the next part of the line
  function automatic void parse_byte(logic [7:0] c);
    logic [16:0] nxt;
    pstate_t     at;
    at = ps;
    if (at == ST_NEWLINE) begin
      if (c == CH_SP || c == CH_HT) begin
        add_char(CH_SP);
        ps = ST_OWS;
        emit(K_VALUE, CH_SP, 16'h0000, E_COLON);
        return;
      end
      emit(K_FEND, 8'h00, trim_len, E_COLON);
      line_bytes = '0;
      at = ST_INIT;
    end
    if (at == ST_INIT) begin
      val_len   = '0;
      trim_len  = '0;
      name_seen = 1'b0;
      if (c == CH_CR) begin
        ps = ST_EOH_LF;
        return;
      end
      if (c == CH_LF) begin
        ps = ST_DONE;
        emit(K_HEND, 8'h00, 16'h0000, E_COLON);
        return;
      end
      ps = ST_NAME;
      at = ST_NAME;
    end
    if (at == ST_NAME) begin
      if (is_tchar(c)) begin
        name_seen = 1'b1;
        emit(K_NAME, c, 16'h0000, E_COLON);
        return;
      end
      if (!name_seen) begin
        fail_with(E_EMPTY);
        return;
      end
      if (c != CH_COLON) begin
        fail_with(E_COLON);
        return;
      end
      nxt = {1'b0, fields_done} + 17'd1;
      if (count_limit != 0 && nxt > {1'b0, count_limit}) begin
        fail_with(E_FIELDS);
        return;
      end
      fields_done = nxt[16] ? LEN_MAX : nxt[15:0];
      ps = ST_OWS;
      return;
    end
    if (at == ST_OWS) begin
      if (c == CH_SP || c == CH_HT) return;
      ps = ST_CONTENT;
      at = ST_CONTENT;
    end
    if (at == ST_CONTENT) begin
      if (is_vchar(c)) begin
        add_char(c);
        emit(K_VALUE, c, 16'h0000, E_COLON);
        return;
      end
      if (c == CH_CR) begin
        ps = ST_LF;
        return;
      end
      if (c == CH_LF) begin
        ps = ST_NEWLINE;
        return;
      end
      if (strict_on) fail_with(E_CONTENT);
      return;
    end
    if (at == ST_LF) begin
      if (c != CH_LF) fail_with(E_LF);
      else ps = ST_NEWLINE;
      return;
    end
    if (at == ST_EOH_LF) begin
      if (c != CH_LF) begin
        fail_with(E_CR);
      end else begin
        ps = ST_DONE;
        line_bytes = '0;
        emit(K_HEND, 8'h00, 16'h0000, E_COLON);
      end
    end
  endfunction

  // Results of one request into step_res, last flag on the final one
  function automatic void parse_request(op_t op, logic [7:0] c);
    step_res.delete();
    if (op == OP_RESTART) begin
      clear_parse();
      return;
    end
    if (op == OP_RSVD) return;
    if (err_on) begin
      emit(K_ERR, 8'h00, 16'h0000, err_cd);
    end else if (ps == ST_DONE) begin
      return;
    end else if (op == OP_EOI) begin
      fail_with(E_EARLY_END);
    end else if (hdr_limit != 0 && hdr_bytes >= hdr_limit) begin
      fail_with(E_HDR_BIG);
    end else if (line_limit != 0 && line_bytes > line_limit) begin
      fail_with(E_FIELD_BIG);
    end else begin
      parse_byte(c);
      if (hdr_bytes != WORD_MAX) hdr_bytes++;
      if (ps != ST_DONE && line_bytes != WORD_MAX) line_bytes++;
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  // Offer one request, wait for it to be taken, then predict its results
  task automatic send_request(input op_t op, input logic [7:0] b, input logic use_typed,
                              input res_t typed_res);
    logic ignored;
    while (take_gap()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.in_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ignored = (op == OP_RSVD) || (!err_on && ps == ST_DONE && op != OP_RESTART);
    if (!ignored) items_sent++;
    parse_request(op, b);
    if (use_typed) pending_results.push_back(typed_res);
    else foreach (step_res[i]) pending_results.push_back(step_res[i]);
  endtask

  // Stop offering and wait until every predicted result is back
  task automatic drain_input();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_STRICT:    strict_on   = val[0];
      CFG_MAX_HDR:   hdr_limit   = val;
      CFG_MAX_FIELD: line_limit  = val;
      CFG_MAX_COUNT: count_limit = val[15:0];
      default: ;
    endcase
  endtask

  // Reprogram all registers with the parser idle
  task automatic set_limits(input logic strict_val, input logic [31:0] hdr_val,
                            input logic [31:0] field_val, input logic [15:0] count_val);
    drain_input();
    write_reg(CFG_STRICT, {31'd0, strict_val});
    write_reg(CFG_MAX_HDR, hdr_val);
    write_reg(CFG_MAX_FIELD, field_val);
    write_reg(CFG_MAX_COUNT, {16'd0, count_val});
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic dir_row_t mk_row(op_t op, logic [7:0] b, logic typed, logic [2:0] k,
                                      logic [7:0] ob, logic [3:0] code);
    dir_row_t r;
    r.op                = op;
    r.b                 = b;
    r.typed             = typed;
    r.want.kind         = k;
    r.want.out_byte     = ob;
    r.want.value_length = 16'h0000;
    r.want.error_code   = code;
    r.want.last         = 1'b1;
    return r;
  endfunction

  function automatic void add_req(op_t op, logic [7:0] b);
    req_t r;
    r.op = op;
    r.b  = b;
    hdr_seq.push_back(r);
  endfunction

  function automatic logic [7:0] pick_tchar();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!is_tchar(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? CH_SP : CH_HT;
  endfunction

  // Mostly text, with blanks, high bytes and the odd control byte
  function automatic logic [7:0] pick_vchar();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(33, 126));
    if (r < 70) return pick_blank();
    if (r < 85) return 8'($urandom_range(128, 255));
    if (r < 95) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_eol();
    if ($urandom_range(1)) add_req(OP_DATA, CH_CR);
    add_req(OP_DATA, CH_LF);
  endfunction

  // One header: mostly well formed with random content, some noise or damage
  function automatic void build_header();
    int unsigned n_fields, len, style, k;
    hdr_seq.delete();
    add_req(OP_RESTART, 8'h00);
    style = $urandom_range(99);
    if (style < 8) begin
      len = $urandom_range(1, 20);
      repeat (len) add_req(op_t'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    n_fields = $urandom_range(0, 4);
    repeat (n_fields) begin
      len = $urandom_range(1, 8);
      repeat (len) add_req(OP_DATA, pick_tchar());
      add_req(OP_DATA, CH_COLON);
      len = $urandom_range(0, 2);
      repeat (len) add_req(OP_DATA, pick_blank());
      len = $urandom_range(0, 14);
      repeat (len) add_req(OP_DATA, pick_vchar());
      if ($urandom_range(3) == 0) add_req(OP_DATA, pick_blank());
      add_eol();
      // continuation line
      if ($urandom_range(4) == 0) begin
        add_req(OP_DATA, pick_blank());
        len = $urandom_range(1, 6);
        repeat (len) add_req(OP_DATA, pick_vchar());
        add_eol();
      end
    end
    if ($urandom_range(3) != 0) add_eol();
    else add_req(OP_EOI, 8'h00);
    if ($urandom_range(4) == 0) begin
      add_req(OP_DATA, 8'($urandom_range(255)));
      add_req(OP_EOI, 8'h00);
    end
    // damage one request
    if (style < 22 && hdr_seq.size() > 1) begin
      k = $urandom_range(1, hdr_seq.size() - 1);
      hdr_seq[k].b = 8'($urandom_range(255));
      if (style < 12) hdr_seq[k].op = op_t'($urandom_range(3));
    end
  endfunction

  task automatic run_random(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      build_header();
      foreach (hdr_seq[k]) send_request(hdr_seq[k].op, hdr_seq[k].b, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= !take_gap();
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind         = out_ch.kind;
      got.out_byte     = out_ch.out_byte;
      got.value_length = out_ch.value_length;
      got.error_code   = out_ch.error_code;
      got.last         = out_ch.last;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result kind=%0d byte=%02h len=%0d code=%0d last=%0b",
                   $realtime, got.kind, got.out_byte, got.value_length, got.error_code,
                   got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
            got.value_length !== want.value_length ||
            got.error_code !== want.error_code || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: result mismatch, expected kind=%0d byte=%02h len=%0d code=%0d last=%0b",
                     $realtime, want.kind, want.out_byte, want.value_length,
                     want.error_code, want.last);
            $display("    got kind=%0d byte=%02h len=%0d code=%0d last=%0b",
                     got.kind, got.out_byte, got.value_length, got.error_code,
                     got.last);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.op      <= OP_DATA;
    in_ch.in_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_STRICT;
    cfg_ch.data   <= 32'h0;
    rst_n         <= 1'b0;
    gaps_on     = 1'b1;
    hold_left   = 0;
    items_sent  = 0;
    mismatches  = 0;
    cycles      = 0;
    strict_on   = 1'b0;
    hdr_limit   = '0;
    line_limit  = '0;
    count_limit = '0;
    clear_parse();

    // Directed requests under reset settings
    dir_rows.push_back(mk_row(OP_EOI,     8'h00, 1'b1, K_ERR,   8'h00, E_EARLY_END));
    dir_rows.push_back(mk_row(OP_DATA,    "A",   1'b1, K_ERR,   8'h00, E_EARLY_END));
    dir_rows.push_back(mk_row(OP_RESTART, 8'h00, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    ":",   1'b1, K_ERR,   8'h00, E_EMPTY));
    dir_rows.push_back(mk_row(OP_RESTART, 8'hFF, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    "H",   1'b1, K_NAME,  "H",   E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    8'h7E, 1'b1, K_NAME,  8'h7E, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    ":",   1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_SP, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    8'hFF, 1'b1, K_VALUE, 8'hFF, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    8'h00, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_HT, 1'b1, K_VALUE, CH_HT, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_CR, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_LF, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_HT, 1'b1, K_VALUE, CH_SP, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    "z",   1'b1, K_VALUE, "z",   E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_LF, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    "B",   1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    "x",   1'b1, K_NAME,  "x",   E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_SP, 1'b1, K_ERR,   8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_RESTART, 8'h00, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_CR, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    "q",   1'b1, K_ERR,   8'h00, E_CR));
    dir_rows.push_back(mk_row(OP_RESTART, 8'h00, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    CH_LF, 1'b1, K_HEND,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_DATA,    "a",   1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_EOI,     8'h00, 1'b0, K_NAME,  8'h00, E_COLON));
    dir_rows.push_back(mk_row(OP_RSVD,    8'h55, 1'b0, K_NAME,  8'h00, E_COLON));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    // Strict content; receiver holds off while requests keep coming
    set_limits(1'b1, 32'd0, 32'd0, 16'd0);
    hold_left = HOLD_CYCLES;
    run_random(PHASE_ITEMS);

    // Tight limits: header, line and field count errors
    set_limits(1'b0, 32'd40, 32'd12, 16'd2);
    run_random(PHASE_ITEMS);

    // Largest limits, no idling on either side, drain halfway
    set_limits(1'b1, WORD_MAX, WORD_MAX, LEN_MAX);
    gaps_on = 1'b0;
    run_random(PHASE_ITEMS / 2);
    drain_input();
    run_random(PHASE_ITEMS / 2);
    gaps_on = 1'b1;

    // Smallest nonzero limits
    set_limits(1'b0, 32'd1, 32'd1, 16'd1);
    run_random(PHASE_ITEMS);

    // Random moderate limits
    set_limits(1'b1, 32'($urandom_range(20, 200)), 32'($urandom_range(5, 40)),
               16'($urandom_range(1, 6)));
    run_random(PHASE_ITEMS);

    // Unlimited again
    set_limits(1'b0, 32'd0, 32'd0, 16'd0);
    run_random(PHASE_ITEMS);

    drain_input();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ http_header_field_parser_core.f @@
+incdir+design
design/hhfp_pkg.sv
design/hhfp_ifs.sv
design/hhfp_front.sv
design/hhfp_queue.sv
design/hhfp_back.sv
design/http_header_field_parser_core.sv
bench/http_header_field_parser_core_tb.sv
